// ----- design/m4rt_pkg.sv -----
// ----------------------------------------------------------------------------
// m4rt_pkg: shared constants and helpers for the 4x4 row transform
// Register codes, matrix dimensions and the reset value of the right matrix.
// ----------------------------------------------------------------------------
package m4rt_pkg;

  localparam int unsigned DIM       = 4;
  localparam int unsigned CFG_W     = 64;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_RHS_ROW0 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RHS_ROW1 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RHS_ROW2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RHS_ROW3 = 2'd3;

  // Identity row k: 1.0 on the diagonal element, zero where it falls past the register.
  function automatic logic [CFG_W-1:0] identity_row(int unsigned k, int unsigned ew,
                                                     int unsigned frac);
    logic [2*CFG_W-1:0] wide;
    wide = (2*CFG_W)'(1) << (frac + k*ew);
    return wide[CFG_W-1:0];
  endfunction

endpackage

// ----- design/m4rt_row_if.sv -----
// ----------------------------------------------------------------------------
// m4rt_row_if: input channel, one row of the left matrix
// Valid/ready handshake with four signed elements.
// ----------------------------------------------------------------------------
interface m4rt_row_if #(
  parameter int unsigned ELEMENT_WIDTH = 16
);
  logic                            valid;
  logic                            ready;
  logic signed [ELEMENT_WIDTH-1:0] a0;
  logic signed [ELEMENT_WIDTH-1:0] a1;
  logic signed [ELEMENT_WIDTH-1:0] a2;
  logic signed [ELEMENT_WIDTH-1:0] a3;

  modport source (output valid, a0, a1, a2, a3, input ready);
  modport sink   (input valid, a0, a1, a2, a3, output ready);
endinterface

// ----- design/m4rt_res_if.sv -----
// ----------------------------------------------------------------------------
// m4rt_res_if: output channel, one row of the product
// Valid/ready handshake with four saturated elements and a clip flag.
// ----------------------------------------------------------------------------
interface m4rt_res_if #(
  parameter int unsigned ELEMENT_WIDTH = 16
);
  logic                            valid;
  logic                            ready;
  logic signed [ELEMENT_WIDTH-1:0] c0;
  logic signed [ELEMENT_WIDTH-1:0] c1;
  logic signed [ELEMENT_WIDTH-1:0] c2;
  logic signed [ELEMENT_WIDTH-1:0] c3;
  logic                            clipped;

  modport source (output valid, c0, c1, c2, c3, clipped, input ready);
  modport sink   (input valid, c0, c1, c2, c3, clipped, output ready);
endinterface

// ----- design/m4rt_cell.sv -----
// ----------------------------------------------------------------------------
// m4rt_cell: one multiply-accumulate cell of the chain
// Adds a[K] times row K of the right matrix to four running column sums.
// ----------------------------------------------------------------------------
module m4rt_cell #(
  parameter int unsigned ELEMENT_WIDTH = 16,
  parameter int unsigned ACC_W         = 34,
  parameter int unsigned K             = 0
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         in_valid,
  output logic                                         up_ready,
  output logic                                         out_valid,
  input  logic                                         down_ready,
  input  logic [m4rt_pkg::CFG_W-1:0]                   rhs_row,
  input  logic [m4rt_pkg::DIM-1:0][ELEMENT_WIDTH-1:0]  a_in,
  output logic [m4rt_pkg::DIM-1:0][ELEMENT_WIDTH-1:0]  a_out,
  input  logic [m4rt_pkg::DIM-1:0][ACC_W-1:0]          psum_in,
  output logic [m4rt_pkg::DIM-1:0][ACC_W-1:0]          psum_out
);

  localparam int unsigned PROD_W = 2 * ELEMENT_WIDTH;

  logic [2*m4rt_pkg::CFG_W-1:0]                padded;
  logic [m4rt_pkg::DIM-1:0][ACC_W-1:0]         psum_next;
  logic signed [PROD_W-1:0]                    prod;
  logic signed [ELEMENT_WIDTH-1:0]             elem;

  assign padded   = {{m4rt_pkg::CFG_W{1'b0}}, rhs_row};
  assign up_ready = !out_valid || down_ready;

  always_comb begin
    for (int j = 0; j < int'(m4rt_pkg::DIM); j++) begin
      elem = $signed(padded[j*ELEMENT_WIDTH +: ELEMENT_WIDTH]);
      prod = $signed(a_in[K]) * elem;
      psum_next[j] = ACC_W'($signed(psum_in[j]) + ACC_W'(prod));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (up_ready) begin
      out_valid <= in_valid;
    end
  end

  // Payload: load on every advance, no reset needed.
  always_ff @(posedge clk) begin
    if (up_ready) begin
      a_out    <= a_in;
      psum_out <= psum_next;
    end
  end

endmodule

// ----- design/m4rt_sat.sv -----
// ----------------------------------------------------------------------------
// m4rt_sat: output stage
// Floor-shifts the column sums, saturates them and holds the result row.
// ----------------------------------------------------------------------------
module m4rt_sat #(
  parameter int unsigned ELEMENT_WIDTH = 16,
  parameter int unsigned FRAC_BITS     = 8,
  parameter int unsigned ACC_W         = 34
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                up_ready,
  input  logic [m4rt_pkg::DIM-1:0][ACC_W-1:0] psum_in,
  m4rt_res_if.source                          res
);

  localparam logic signed [ACC_W-1:0] MAXV =
    {{(ACC_W-ELEMENT_WIDTH+1){1'b0}}, {(ELEMENT_WIDTH-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] MINV = ~MAXV;

  logic [m4rt_pkg::DIM-1:0][ELEMENT_WIDTH-1:0] c_next;
  logic [m4rt_pkg::DIM-1:0]                    clip_col;
  logic [m4rt_pkg::DIM-1:0][ELEMENT_WIDTH-1:0] c;
  logic signed [ACC_W-1:0]                     shifted;
  logic                                        clipped;

  assign up_ready = !res.valid || res.ready;

  always_comb begin
    for (int j = 0; j < int'(m4rt_pkg::DIM); j++) begin
      shifted = $signed(psum_in[j]) >>> FRAC_BITS;
      if (shifted > MAXV) begin
        c_next[j]   = MAXV[ELEMENT_WIDTH-1:0];
        clip_col[j] = 1'b1;
      end else if (shifted < MINV) begin
        c_next[j]   = MINV[ELEMENT_WIDTH-1:0];
        clip_col[j] = 1'b1;
      end else begin
        c_next[j]   = shifted[ELEMENT_WIDTH-1:0];
        clip_col[j] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (up_ready) begin
      res.valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      c       <= c_next;
      clipped <= |clip_col;
    end
  end

  assign res.c0      = $signed(c[0]);
  assign res.c1      = $signed(c[1]);
  assign res.c2      = $signed(c[2]);
  assign res.c3      = $signed(c[3]);
  assign res.clipped = clipped;

endmodule

// ----- design/matrix4_row_transform_unit.sv -----
// ----------------------------------------------------------------------------
// matrix4_row_transform_unit: one row of a 4x4 fixed-point matrix product
// Multiplies each incoming left-matrix row by the right matrix held in four
// configuration registers, producing a saturated fixed-point result row.
// ----------------------------------------------------------------------------
//
//   channel   dir   handshake          payload
//   row       in    valid / ready      a0..a3   signed, ELEMENT_WIDTH each
//   res       out   valid / ready      c0..c3   signed, clipped flag
//   cfg       in    cfg_we (no wait)   cfg_index, cfg_data (64 bits)
//
// Throughput is one item per cycle unless a stall at res fills the chain; each
// item passes through the chain of four multiply-accumulate cells (one per
// right-matrix row) and then the saturating output register.
// Each stage advances when its successor is empty or advancing, so bubbles
// collapse and the chain keeps taking items while a result waits at res.
// Synchronous reset clears all valid bits and loads the identity matrix.
//
module matrix4_row_transform_unit #(
  parameter int unsigned ELEMENT_WIDTH = 16,
  parameter int unsigned FRAC_BITS     = 8
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [m4rt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [m4rt_pkg::CFG_W-1:0]         cfg_data,
  m4rt_row_if.sink                           row,
  m4rt_res_if.source                         res
);

  // Exact sum of four full-width products needs two guard bits.
  localparam int unsigned ACC_W = 2 * ELEMENT_WIDTH + 2;
  localparam int unsigned DIM   = m4rt_pkg::DIM;

  // Right matrix, one register per row.
  logic [DIM-1:0][m4rt_pkg::CFG_W-1:0] rhs;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < int'(DIM); k++) begin
        rhs[k] <= m4rt_pkg::identity_row(k, ELEMENT_WIDTH, FRAC_BITS);
      end
    end else if (cfg_we) begin
      case (cfg_index)
        m4rt_pkg::REG_RHS_ROW0: rhs[0] <= cfg_data;
        m4rt_pkg::REG_RHS_ROW1: rhs[1] <= cfg_data;
        m4rt_pkg::REG_RHS_ROW2: rhs[2] <= cfg_data;
        m4rt_pkg::REG_RHS_ROW3: rhs[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Chain links: index 0 is the input side, index DIM feeds the output stage.
  logic [DIM:0]                                 link_valid;
  logic [DIM:0]                                 link_ready;
  logic [DIM:0][DIM-1:0][ELEMENT_WIDTH-1:0]     link_a;
  logic [DIM:0][DIM-1:0][ACC_W-1:0]             link_psum;

  assign link_valid[0] = row.valid;
  assign row.ready     = link_ready[0];
  assign link_a[0]     = {row.a3, row.a2, row.a1, row.a0};
  assign link_psum[0]  = '0;

  // Cell k adds a[k] times row k of the right matrix, then hands on.
  for (genvar k = 0; k < DIM; k++) begin : g_cell
    m4rt_cell #(
      .ELEMENT_WIDTH (ELEMENT_WIDTH),
      .ACC_W         (ACC_W),
      .K             (k)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .in_valid   (link_valid[k]),
      .up_ready   (link_ready[k]),
      .out_valid  (link_valid[k+1]),
      .down_ready (link_ready[k+1]),
      .rhs_row    (rhs[k]),
      .a_in       (link_a[k]),
      .a_out      (link_a[k+1]),
      .psum_in    (link_psum[k]),
      .psum_out   (link_psum[k+1])
    );
  end

  // Shift, saturate and hold the finished row for res.
  m4rt_sat #(
    .ELEMENT_WIDTH (ELEMENT_WIDTH),
    .FRAC_BITS     (FRAC_BITS),
    .ACC_W         (ACC_W)
  ) u_sat (
    .clk      (clk),
    .rst      (rst),
    .in_valid (link_valid[DIM]),
    .up_ready (link_ready[DIM]),
    .psum_in  (link_psum[DIM]),
    .res      (res)
  );

endmodule

// ----- sim/matrix4_row_transform_unit_tb.sv -----
// ----------------------------------------------------------------------------
// matrix4_row_transform_unit_tb: self-checking bench for the 4x4 row transform
// Loads a series of right-hand matrices, streams left-matrix rows through the
// valid/ready channels under random backpressure, and compares every result
// row against an exact-arithmetic, saturating fixed-point product.
// ----------------------------------------------------------------------------
package m4rt_check_pkg;

  localparam int unsigned EW       = 16;
  localparam int unsigned FRAC     = 8;
  localparam longint      ELEM_MAX = (longint'(1) << (EW - 1)) - 1;
  localparam longint      ELEM_MIN = -(longint'(1) << (EW - 1));

  typedef logic [3:0][EW-1:0]               quad_t;
  typedef logic [3:0][m4rt_pkg::CFG_W-1:0]  rhs_matrix_t;

  typedef struct packed {
    quad_t c;
    logic  clipped;
  } prod_row_t;

  class row_product_scoreboard;
    rhs_matrix_t rhs;
    prod_row_t   expected_rows[$];
    int unsigned rows_noted;
    int unsigned rows_checked;
    int unsigned clipped_rows;
    int unsigned mismatches;

    function new();
      for (int k = 0; k < 4; k++) begin
        rhs[k] = m4rt_pkg::CFG_W'(longint'(1) << (FRAC + k * EW));
      end
      rows_noted   = 0;
      rows_checked = 0;
      clipped_rows = 0;
      mismatches   = 0;
    endfunction

    function void write_rhs(logic [m4rt_pkg::CFG_IDX_W-1:0] idx,
                            logic [m4rt_pkg::CFG_W-1:0] val);
      rhs[idx] = val;
    endfunction

    // Exact dot products, floor shift, clamp to the element range.
    function prod_row_t transform_row(quad_t a);
      prod_row_t            r;
      longint               acc;
      logic signed [EW-1:0] ak;
      logic signed [EW-1:0] rkj;
      r = '0;
      for (int j = 0; j < 4; j++) begin
        acc = 0;
        for (int k = 0; k < 4; k++) begin
          ak  = a[k];
          rkj = rhs[k][j*EW +: EW];
          acc += longint'(ak) * longint'(rkj);
        end
        acc = acc >>> FRAC;
        if (acc > ELEM_MAX) begin
          acc       = ELEM_MAX;
          r.clipped = 1'b1;
        end else if (acc < ELEM_MIN) begin
          acc       = ELEM_MIN;
          r.clipped = 1'b1;
        end
        r.c[j] = EW'(acc);
      end
      return r;
    endfunction

    function void note_row(quad_t a);
      expected_rows.push_back(transform_row(a));
      rows_noted++;
    endfunction

    function void report(string what, prod_row_t want, prod_row_t got);
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t %s: want %0d %0d %0d %0d clip %0b, got %0d %0d %0d %0d clip %0b",
                 $time, what,
                 $signed(want.c[0]), $signed(want.c[1]), $signed(want.c[2]),
                 $signed(want.c[3]), want.clipped,
                 $signed(got.c[0]), $signed(got.c[1]), $signed(got.c[2]),
                 $signed(got.c[3]), got.clipped);
      end
    endfunction

    function void check_result(prod_row_t got);
      prod_row_t want;
      bit        bad;
      rows_checked++;
      if (expected_rows.size() == 0) begin
        report("result with no row pending", '0, got);
      end else begin
        want = expected_rows.pop_front();
        bad  = (got.clipped !== want.clipped);
        for (int j = 0; j < 4; j++) begin
          if (got.c[j] !== want.c[j]) bad = 1'b1;
        end
        if (want.clipped) clipped_rows++;
        if (bad) report("result row mismatch", want, got);
      end
    endfunction
  endclass

endpackage

module matrix4_row_transform_unit_tb;

  // Pipeline depth from the block header: four MAC cells plus the output stage.
  localparam int unsigned LATENCY         = 5;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned RANDOM_SETS     = 8;
  localparam int unsigned ROWS_PER_SET    = 215;
  localparam int unsigned PRESSURE_SET    = 3;
  localparam int unsigned CYCLE_LIMIT     = 500000;

  localparam logic [m4rt_pkg::CFG_IDX_W-1:0] RHS_REG [4] =
    '{m4rt_pkg::REG_RHS_ROW0, m4rt_pkg::REG_RHS_ROW1,
      m4rt_pkg::REG_RHS_ROW2, m4rt_pkg::REG_RHS_ROW3};

  localparam logic [m4rt_check_pkg::EW-1:0] ELEM_MOST_NEG = 16'h8000;
  localparam logic [m4rt_check_pkg::EW-1:0] ELEM_MOST_POS = 16'h7FFF;
  localparam logic [m4rt_check_pkg::EW-1:0] ELEM_MINUS_1  = 16'hFFFF;
  localparam logic [m4rt_check_pkg::EW-1:0] ELEM_LSB      = 16'h0001;

  typedef enum int {
    MAT_SMALL,
    MAT_FULL,
    MAT_DIAGONAL,
    MAT_MIXED
  } mat_style_t;

  logic                           clk       = 1'b0;
  logic                           rst       = 1'b1;
  logic                           cfg_we    = 1'b0;
  logic [m4rt_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [m4rt_pkg::CFG_W-1:0]     cfg_data  = '0;

  m4rt_row_if #(.ELEMENT_WIDTH(m4rt_check_pkg::EW)) row_ch ();
  m4rt_res_if #(.ELEMENT_WIDTH(m4rt_check_pkg::EW)) res_ch ();

  matrix4_row_transform_unit #(
    .ELEMENT_WIDTH(m4rt_check_pkg::EW),
    .FRAC_BITS    (m4rt_check_pkg::FRAC)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .row      (row_ch),
    .res      (res_ch)
  );

  m4rt_check_pkg::row_product_scoreboard sb = new();

  // Shared knobs idle_on and hold_offs_asked: stimulus writes, sink reads.
  bit          idle_on         = 1'b0;
  int unsigned hold_offs_asked = 0;
  int unsigned matrix_sets     = 0;
  int unsigned cycles          = 0;

  always #4 clk = ~clk;

  // Watchdog: end the run if it hangs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d rows still pending",
               cycles, sb.expected_rows.size());
      $display("Mismatches found");
      $finish;
    end
  end

  // Sample the result channel at the rising edge and check each accepted item.
  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready) begin
      sb.check_result('{c: {res_ch.c3, res_ch.c2, res_ch.c1, res_ch.c0},
                        clipped: res_ch.clipped});
    end
  end

  // Result sink: random stall bursts while idling is on; on request, hold ready
  // low for a long stretch so the pipe fills and the row channel backs up.
  initial begin : result_sink
    int unsigned stall;
    int unsigned hold_offs_done;
    stall          = 0;
    hold_offs_done = 0;
    res_ch.ready   = 1'b0;
    forever begin
      @(negedge clk);
      if (rst) begin
        res_ch.ready = 1'b0;
      end else if (hold_offs_done < hold_offs_asked) begin
        res_ch.ready = 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        hold_offs_done++;
      end else if (stall > 0) begin
        res_ch.ready = 1'b0;
        stall--;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        res_ch.ready = 1'b0;
        stall        = $urandom_range(0, 13);
      end else begin
        res_ch.ready = 1'b1;
      end
    end
  end

  function automatic m4rt_check_pkg::quad_t quad(int e0, int e1, int e2, int e3);
    return {m4rt_check_pkg::EW'(e3), m4rt_check_pkg::EW'(e2),
            m4rt_check_pkg::EW'(e1), m4rt_check_pkg::EW'(e0)};
  endfunction

  function automatic logic [m4rt_check_pkg::EW-1:0] rand_small(int unsigned m);
    return m4rt_check_pkg::EW'($urandom_range(0, 2 * m)) - m4rt_check_pkg::EW'(m);
  endfunction

  function automatic logic [m4rt_check_pkg::EW-1:0] rand_extreme();
    case ($urandom_range(0, 4))
      0:       return ELEM_MOST_NEG;
      1:       return ELEM_MOST_POS;
      2:       return '0;
      3:       return ELEM_MINUS_1;
      default: return ELEM_LSB;
    endcase
  endfunction

  function automatic m4rt_check_pkg::rhs_matrix_t rand_matrix(mat_style_t style);
    m4rt_check_pkg::rhs_matrix_t   m;
    logic [m4rt_check_pkg::EW-1:0] e;
    for (int k = 0; k < 4; k++) begin
      for (int j = 0; j < 4; j++) begin
        case (style)
          MAT_SMALL: e = rand_small(512);
          MAT_FULL:  e = m4rt_check_pkg::EW'($urandom);
          MAT_DIAGONAL: begin
            if (k == j) e = rand_small(1024);
            else        e = ($urandom_range(0, 3) == 0) ? rand_small(16) : '0;
          end
          default: begin
            case ($urandom_range(0, 2))
              0:       e = rand_small(768);
              1:       e = m4rt_check_pkg::EW'($urandom);
              default: e = rand_extreme();
            endcase
          end
        endcase
        m[k][j*m4rt_check_pkg::EW +: m4rt_check_pkg::EW] = e;
      end
    end
    return m;
  endfunction

  // Moderate rows are the largest share so results land in range; full-range
  // and extreme rows drive the saturation paths.
  function automatic m4rt_check_pkg::quad_t rand_row();
    m4rt_check_pkg::quad_t a;
    int unsigned           pick;
    pick = $urandom_range(0, 99);
    for (int j = 0; j < 4; j++) begin
      if (pick < 45)      a[j] = rand_small(1024);
      else if (pick < 75) a[j] = m4rt_check_pkg::EW'($urandom);
      else if (pick < 90) a[j] = rand_extreme();
      else                a[j] = $urandom_range(0, 1) ? '0 : m4rt_check_pkg::EW'($urandom);
    end
    return a;
  endfunction

  // Enter and leave at a falling edge. Valid stays high between items unless
  // an idle burst drops it.
  task automatic send_row(input m4rt_check_pkg::quad_t a);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      row_ch.valid = 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    row_ch.a0    = a[0];
    row_ch.a1    = a[1];
    row_ch.a2    = a[2];
    row_ch.a3    = a[3];
    row_ch.valid = 1'b1;
    @(posedge clk);
    while (!row_ch.ready) @(posedge clk);
    sb.note_row(a);
    @(negedge clk);
  endtask

  // Drop valid, wait for every pending row to come back, then let the pipe
  // run empty before touching the configuration.
  task automatic settle();
    row_ch.valid = 1'b0;
    while (sb.expected_rows.size() != 0) @(negedge clk);
    repeat (LATENCY + 2) @(negedge clk);
  endtask

  task automatic load_matrix(input m4rt_check_pkg::rhs_matrix_t m);
    for (int k = 0; k < 4; k++) begin
      cfg_we    = 1'b1;
      cfg_index = RHS_REG[k];
      cfg_data  = m[k];
      sb.write_rhs(RHS_REG[k], m[k]);
      @(negedge clk);
    end
    cfg_we = 1'b0;
    matrix_sets++;
  endtask

  initial begin : stimulus
    row_ch.valid = 1'b0;
    row_ch.a0    = '0;
    row_ch.a1    = '0;
    row_ch.a2    = '0;
    row_ch.a3    = '0;
    repeat (12) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    // Reset matrix is the identity: every row must pass through unchanged,
    // including the most negative and most positive elements and bit toggles.
    idle_on = 1'b1;
    send_row(quad(0, 0, 0, 0));
    send_row(quad(32767, -32768, 1, -1));
    send_row(quad(-32768, 32767, -1, 1));
    send_row(quad(256, -256, 16'h1234, 16'h5A5A));
    send_row(quad(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555));
    send_row(quad(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA));
    settle();

    // Every element -128.0: the largest exact sum (2^32 before the shift)
    // must saturate, not wrap; 1.0 times -128.0 lands exactly on the minimum.
    idle_on = 1'b0;
    load_matrix({4{64'h8000_8000_8000_8000}});
    send_row(quad(-32768, -32768, -32768, -32768));
    send_row(quad(32767, 32767, 32767, 32767));
    send_row(quad(256, 0, 0, 0));
    send_row(quad(-1, 0, 0, 0));
    send_row(quad(1, 1, 1, 1));
    send_row(quad(-32768, 0, 0, 0));
    settle();

    // Every element at the top of the range: exactly at the maximum, one step
    // over it, and the floor of small negative products.
    load_matrix({4{64'h7FFF_7FFF_7FFF_7FFF}});
    send_row(quad(256, 0, 0, 0));
    send_row(quad(257, 0, 0, 0));
    send_row(quad(-1, 0, 0, 0));
    send_row(quad(-256, 0, 0, 0));
    send_row(quad(-32768, -32768, -32768, -32768));
    settle();

    // Mixed signs and fractions: floor rounding toward minus infinity and
    // columns that clip while others do not.
    idle_on = 1'b1;
    load_matrix({64'hFFFF_0000_0200_0000, 64'h0001_8000_0000_0100,
                 64'h7FFF_0000_FF80_0040, 64'hFF00_0100_0080_FFFF});
    send_row(quad(1, 0, 0, 0));
    send_row(quad(32767, -32768, 32767, -32768));
    send_row(quad(-3, 5, -7, 9));
    send_row(quad(12345, -12345, 100, -100));
    settle();

    // Random matrices with random rows. One set stalls the result side for a
    // long stretch; the last set runs with no idling at all.
    for (int unsigned p = 0; p < RANDOM_SETS; p++) begin
      load_matrix(rand_matrix(mat_style_t'(p % 4)));
      if (p == PRESSURE_SET) hold_offs_asked++;
      for (int unsigned i = 0; i < ROWS_PER_SET; i++) begin
        if (i % 40 == 0) idle_on = (p != RANDOM_SETS - 1) && ($urandom_range(0, 3) != 0);
        send_row(rand_row());
      end
      settle();
    end

    $display("Covered %0d rows under %0d right-hand matrices, %0d of them saturated",
             sb.rows_noted, matrix_sets, sb.clipped_rows);
    $display("Compared %0d result rows, %0d bad", sb.rows_checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.expected_rows.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/m4rt_pkg.sv
design/m4rt_row_if.sv
design/m4rt_res_if.sv
design/m4rt_cell.sv
design/m4rt_sat.sv
design/matrix4_row_transform_unit.sv
sim/matrix4_row_transform_unit_tb.sv
